FILE: sv/rsadk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsadk_pkg
// shared constants of the rsa decrypt block with key derivation
// ----------------------------------------------------------------------------
package rsadk_pkg;

    localparam int WORD_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS);

    localparam int CFG_IDX_BITS = 2;

    typedef logic [WORD_BITS-1:0]    t_word;
    typedef logic [PROD_BITS-1:0]    t_prod;
    typedef logic [CNT_BITS-1:0]     t_cnt;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_MODULUS         = t_cfg_idx'(0);
    localparam t_cfg_idx REG_PUBLIC_EXPONENT = t_cfg_idx'(1);

    // reset key
    localparam t_word MODULUS_RESET  = t_word'(3233);
    localparam t_word PUB_EXP_RESET  = t_word'(17);

endpackage : rsadk_pkg
`default_nettype wire

FILE: sv/rsa_decrypt_with_key_derivation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_decrypt_with_key_derivation
// textbook rsa decryption with private exponent derived from n and e
// ----------------------------------------------------------------------------
// decryption: square-and-multiply through one shared bit-serial remainder
// the first word after a reset or key write first derives the key: one gcd run
//   for each value below n, then a search over inverse candidates
// throughput: one word at a time; a new word is taken once the block is idle
// reset: synchronous, active low; key returns to n = 3233, e = 17, not derived
// ----------------------------------------------------------------------------
module rsa_decrypt_with_key_derivation
    import rsadk_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [WORD_BITS-1:0]    i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [WORD_BITS-1:0]    i_code_word,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [WORD_BITS-1:0]         o_plain_value,
    output logic [7:0]                   o_plain_char,
    output logic                         o_key_error
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TOT_LOOP = 4'd1;
    localparam logic [3:0] S_GCD_RET  = 4'd2;
    localparam logic [3:0] S_INV_LOOP = 4'd3;
    localparam logic [3:0] S_INV_RET  = 4'd4;
    localparam logic [3:0] S_POW_INIT = 4'd5;
    localparam logic [3:0] S_POW_BASE = 4'd6;
    localparam logic [3:0] S_POW_LOOP = 4'd7;
    localparam logic [3:0] S_POW_RMUL = 4'd8;
    localparam logic [3:0] S_POW_SQ   = 4'd9;
    localparam logic [3:0] S_MODP     = 4'd10;
    localparam logic [3:0] S_REM      = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0] r_state, n_state;
    logic [3:0] r_ret, n_ret;
    logic       r_key_ok, n_key_ok;
    t_word      r_modulus, n_modulus;
    t_word      r_pub_exp, n_pub_exp;
    t_word      r_code, n_code;
    t_word      r_i, n_i;
    t_word      r_count, n_count;
    t_word      r_tot, n_tot;
    t_word      r_d, n_d;
    t_word      r_y, n_y;
    t_word      r_res, n_res;
    t_word      r_base, n_base;
    t_word      r_exp, n_exp;
    t_prod      r_prod, n_prod;
    t_word      r_div, n_div;
    t_word      r_rem, n_rem;
    t_prod      r_dvd, n_dvd;
    t_cnt       r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    t_word      r_plain, n_plain;
    logic       r_err, n_err;

    logic                 in_acc;
    logic                 rem_go;
    t_prod                rem_val;
    t_word                mul_a, mul_b;
    t_prod                mul_p;
    logic [WORD_BITS:0]   rem_t;
    logic [WORD_BITS:0]   rem_s;

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_plain_value = r_plain;
    assign o_plain_char  = r_plain[7:0];
    assign o_key_error   = r_err;

    assign in_acc = i_in_valid && o_in_ready;
    assign mul_p  = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    // multiplier operands
    always_comb begin
        mul_a = r_base;
        mul_b = r_base;
        if (r_state == S_INV_LOOP) begin
            mul_a = r_i;
            mul_b = r_pub_exp;
        end else if (r_state == S_POW_LOOP && r_exp[0]) begin
            mul_a = r_res;
        end
    end

    // one restoring remainder step
    assign rem_t = {r_rem, r_dvd[PROD_BITS-1]};
    assign rem_s = rem_t - {1'b0, r_div};

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_key_ok    = r_key_ok;
        n_modulus   = r_modulus;
        n_pub_exp   = r_pub_exp;
        n_code      = r_code;
        n_i         = r_i;
        n_count     = r_count;
        n_tot       = r_tot;
        n_d         = r_d;
        n_y         = r_y;
        n_res       = r_res;
        n_base      = r_base;
        n_exp       = r_exp;
        n_prod      = r_prod;
        n_div       = r_div;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_plain     = r_plain;
        n_err       = r_err;
        rem_go      = 1'b0;
        rem_val     = r_prod;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODULUS: begin
                    n_modulus = i_cfg_data;
                    n_key_ok  = 1'b0;
                end
                REG_PUBLIC_EXPONENT: begin
                    n_pub_exp = i_cfg_data;
                    n_key_ok  = 1'b0;
                end
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_code = i_code_word;
                    if (r_key_ok) begin
                        n_state = S_POW_INIT;
                    end else begin
                        n_i     = t_word'(1);
                        n_count = '0;
                        n_d     = '0;
                        n_state = S_TOT_LOOP;
                    end
                end
            end
            // totient count: gcd(n, i) for i in 1..n-1
            S_TOT_LOOP: begin
                if (r_i < r_modulus) begin
                    rem_go  = 1'b1;
                    rem_val = PROD_BITS'(r_modulus);
                    n_div   = r_i;
                    n_y     = r_i;
                    n_ret   = S_GCD_RET;
                end else begin
                    n_tot   = r_count;
                    n_i     = t_word'(1);
                    n_state = S_INV_LOOP;
                end
            end
            S_GCD_RET: begin
                if (r_rem == '0) begin
                    if (r_y == t_word'(1)) begin
                        n_count = r_count + t_word'(1);
                    end
                    n_i     = r_i + t_word'(1);
                    n_state = S_TOT_LOOP;
                end else begin
                    rem_go  = 1'b1;
                    rem_val = PROD_BITS'(r_y);
                    n_div   = r_rem;
                    n_y     = r_rem;
                    n_ret   = S_GCD_RET;
                end
            end
            // smallest d with d*e mod phi == 1
            S_INV_LOOP: begin
                if (r_i < r_tot) begin
                    n_prod  = mul_p;
                    n_div   = r_tot;
                    n_ret   = S_INV_RET;
                    n_state = S_MODP;
                end else begin
                    n_d      = '0;
                    n_key_ok = 1'b1;
                    n_state  = S_POW_INIT;
                end
            end
            S_INV_RET: begin
                if (r_rem == t_word'(1)) begin
                    n_d      = r_i;
                    n_key_ok = 1'b1;
                    n_state  = S_POW_INIT;
                end else begin
                    n_i     = r_i + t_word'(1);
                    n_state = S_INV_LOOP;
                end
            end
            // square-and-multiply
            S_POW_INIT: begin
                if (r_d == '0) begin
                    n_state = S_DONE;
                end else begin
                    rem_go  = 1'b1;
                    rem_val = PROD_BITS'(r_code);
                    n_div   = r_modulus;
                    n_ret   = S_POW_BASE;
                    n_res   = t_word'(1);
                    n_exp   = r_d;
                end
            end
            S_POW_BASE: begin
                n_base  = r_rem;
                n_state = S_POW_LOOP;
            end
            S_POW_LOOP: begin
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else begin
                    if (r_exp[0]) begin
                        n_ret = S_POW_RMUL;
                    end else begin
                        n_ret = S_POW_SQ;
                    end
                    n_prod  = mul_p;
                    n_div   = r_modulus;
                    n_state = S_MODP;
                end
            end
            S_POW_RMUL: begin
                n_res   = r_rem;
                n_prod  = mul_p;
                n_ret   = S_POW_SQ;
                n_state = S_MODP;
            end
            S_POW_SQ: begin
                n_base  = r_rem;
                n_exp   = r_exp >> 1;
                n_state = S_POW_LOOP;
            end
            S_MODP: begin
                rem_go  = 1'b1;
                rem_val = r_prod;
            end
            S_REM: begin
                n_rem = (rem_t >= {1'b0, r_div}) ? rem_s[WORD_BITS-1:0]
                                                : rem_t[WORD_BITS-1:0];
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt - t_cnt'(1);
                if (r_cnt == '0) begin
                    n_state = r_ret;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_err       = (r_d == '0);
                    n_plain     = (r_d == '0) ? '0 : r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // start of a reduction, skipping an all-zero upper half
        if (rem_go) begin
            n_rem   = '0;
            n_state = S_REM;
            if (rem_val[PROD_BITS-1:WORD_BITS] == '0) begin
                n_dvd = {rem_val[WORD_BITS-1:0], {WORD_BITS{1'b0}}};
                n_cnt = t_cnt'(WORD_BITS - 1);
            end else begin
                n_dvd = rem_val;
                n_cnt = t_cnt'(PROD_BITS - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_ok    <= 1'b0;
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RESET;
            r_pub_exp   <= PUB_EXP_RESET;
        end else begin
            r_state     <= n_state;
            r_key_ok    <= n_key_ok;
            r_out_valid <= n_out_valid;
            r_modulus   <= n_modulus;
            r_pub_exp   <= n_pub_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_code  <= n_code;
        r_i     <= n_i;
        r_count <= n_count;
        r_tot   <= n_tot;
        r_d     <= n_d;
        r_y     <= n_y;
        r_res   <= n_res;
        r_base  <= n_base;
        r_exp   <= n_exp;
        r_prod  <= n_prod;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_cnt   <= n_cnt;
        r_plain <= n_plain;
        r_err   <= n_err;
    end

endmodule : rsa_decrypt_with_key_derivation
`default_nettype wire
